// ===== src/rs_flow_tuple_hash_macros.svh =====
// Assertion macros shared by the checkers of this block.
`ifndef RS_FLOW_TUPLE_HASH_MACROS_SVH
`define RS_FLOW_TUPLE_HASH_MACROS_SVH

// Implication checked in the next cycle, off while reset is asserted.
`define RSFTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsfth check failed");

// Implication checked in the same cycle, off while reset is asserted.
`define RSFTH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsfth check failed");

// Implication checked in the next cycle, active during reset too.
`define RSFTH_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rsfth reset check failed");

`endif

// ===== src/rsfth_pkg.sv =====
package rsfth_pkg;

  localparam int unsigned NumBytes  = 16;
  localparam int unsigned HashWidth = 32;
  localparam int unsigned InWidth   = 96;
  localparam int unsigned NumGroups = 4;
  localparam int unsigned GroupSize = NumBytes / NumGroups;

  localparam logic [HashWidth-1:0] MultStart = 32'd63689;
  localparam logic [HashWidth-1:0] MultStep  = 32'd378551;

  typedef logic [HashWidth-1:0] hash_t;

  // Weight of byte k in the final hash: product of the multipliers used
  // after byte k was absorbed, modulo 2^32.
  function automatic hash_t byte_weight(input int unsigned k);
    hash_t       wgt;
    hash_t       mult;
    logic [63:0] tmp;
    wgt  = 32'd1;
    mult = MultStart;
    for (int unsigned j = 0; j < NumBytes; j++) begin
      if (j > k) begin
        tmp = 64'(wgt) * 64'(mult);
        wgt = tmp[31:0];
      end
      tmp  = 64'(mult) * 64'(MultStep);
      mult = tmp[31:0];
    end
    return wgt;
  endfunction

endpackage

// ===== src/rs_flow_tuple_hash.sv =====
// RS hash of a connection four-tuple, one tuple per cycle unless out_tready stalls.
// An accepted input word passes the product, partial-sum and final-sum register
// stages before out_tvalid; throughput one word per cycle when not stalled.
// Each stage holds its word while the stage after it is full and stalled.
// Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
module rs_flow_tuple_hash (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] local_address, [47:32] local_port_number,
  // [79:48] remote_address, [95:80] remote_port_number
  input  logic [rsfth_pkg::InWidth-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] flow_hash
  output logic [rsfth_pkg::HashWidth-1:0]     out_tdata
);
  import rsfth_pkg::*;

  // The recurrence hash = hash*a + byte uses a fixed sequence of a, so the
  // hash is a sum of each sign-extended byte times a constant weight.
  // Stage 1 forms the sixteen products, stage 2 adds them in groups of four,
  // stage 3 adds the four partial sums.

  logic [8*NumBytes-1:0] tuple_bytes;
  hash_t                 prod_nxt [NumBytes];
  hash_t                 prod_r   [NumBytes];
  hash_t                 sum4_nxt [NumGroups];
  hash_t                 sum4_r   [NumGroups];
  hash_t                 hash_nxt;
  hash_t                 hash_r;
  logic                  v1_r, v2_r, out_valid_r;
  logic                  rdy1, rdy2, rdy3;

  // Ports enter as four-byte fields with two zero upper bytes.
  assign tuple_bytes = {16'h0000, in_tdata[95:80], in_tdata[79:48],
                        16'h0000, in_tdata[47:32], in_tdata[31:0]};

  // Advance a stage when the next one is empty or moving.
  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // Only the low 32 bits of each product matter, so keep the multiply at 32 bits.
  for (genvar k = 0; k < NumBytes; k++) begin : g_lane
    localparam hash_t Weight = byte_weight(k);
    logic [7:0]  b;
    hash_t       b_ext;
    always_comb begin
      b           = tuple_bytes[8*k +: 8];
      b_ext       = {{(HashWidth-8){b[7]}}, b};
      prod_nxt[k] = b_ext * Weight;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      sum4_nxt[g] = prod_r[GroupSize*g] + prod_r[GroupSize*g+1]
                  + prod_r[GroupSize*g+2] + prod_r[GroupSize*g+3];
    end
    hash_nxt = sum4_r[0] + sum4_r[1] + sum4_r[2] + sum4_r[3];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_tvalid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) out_valid_r <= v2_r;
    end
  end

  // Payload: load only when a word actually moves in.
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) prod_r <= prod_nxt;
    if (rdy2 && v1_r)      sum4_r <= sum4_nxt;
    if (rdy3 && v2_r)      hash_r <= hash_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hash_r;

endmodule

// ===== src/rsfth_checker.sv =====
`include "rs_flow_tuple_hash_macros.svh"

module rsfth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Hold a stalled result word.
  `RSFTH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Drop all words on reset.
  `RSFTH_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_tvalid)

  // A free output side never stalls the input side.
  `RSFTH_ASSERT_SAME(a_no_stall, clk, rst_n, out_tready, in_tready)

  // An accepted word reaches the output when out_tready stays high behind it.
  `RSFTH_ASSERT_NEXT(a_latency, clk, rst_n, (in_tvalid && in_tready) ##1 out_tready ##1 out_tready, out_tvalid)

endmodule

bind rs_flow_tuple_hash rsfth_checker u_rsfth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsfth_pkg::*;

  // Stop the run well past the slowest legal schedule: about 1521 words, with
  // random sender gaps and receiver stalls.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;   // pipeline is 3 deep
  localparam int unsigned RandomTuples = 1500;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // [31:0] local_address, [47:32] local_port_number,
  // [79:48] remote_address, [95:80] remote_port_number
  logic [InWidth-1:0]   in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [31:0] flow_hash
  logic [HashWidth-1:0] out_tdata;

  hash_t       pending_hashes[$];   // expected hashes, oldest first
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;      // words left in the current sender burst

  rs_flow_tuple_hash DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // RS hash over the sixteen tuple bytes. Each field is taken low byte first;
  // ports hash as 32-bit words whose upper two bytes are zero. Every byte is
  // sign-extended before it is added, so 0x80..0xFF subtract.
  function automatic hash_t rs_tuple_hash(input logic [31:0] local_addr,
                                          input logic [15:0] lcl_port,
                                          input logic [31:0] remote_addr,
                                          input logic [15:0] rmt_port);
    logic [31:0] fields[4];
    hash_t       acc;
    hash_t       mult;
    logic [7:0]  octet;
    fields[0] = local_addr;
    fields[1] = {16'd0, lcl_port};
    fields[2] = remote_addr;
    fields[3] = {16'd0, rmt_port};
    acc  = '0;
    mult = MultStart;
    for (int f = 0; f < 4; f++) begin
      for (int k = 0; k < 4; k++) begin
        octet = fields[f][8*k +: 8];
        acc   = acc * mult + {{24{octet[7]}}, octet};   // wraps mod 2^32
        mult  = mult * MultStep;
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Send one tuple. The sender runs in bursts: when a burst is used up, drop
  // tvalid for a random gap (possibly none) and draw a new burst length.
  // tvalid stays high from one word to the next inside a burst.
  task automatic send_tuple(input logic [31:0] local_addr, input logic [15:0] lcl_port,
                            input logic [31:0] remote_addr, input logic [15:0] rmt_port);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom, $urandom};   // junk while idle
        repeat (gap) @(posedge clk);
      end
      // Mostly short bursts, now and then a long unbroken stretch.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rmt_port, remote_addr, lcl_port, local_addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_hashes.push_back(rs_tuple_hash(local_addr, lcl_port, remote_addr, rmt_port));
    burst_left--;
  endtask

  // Pick one byte, leaning on the sign boundary and the ends of the range.
  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    return {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
  endfunction

  // Every field at its ends, alone and together.
  task automatic test_field_extremes();
    send_tuple(32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000);
    send_tuple(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_tuple(32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 16'h0000);
    send_tuple(32'h0000_0000, 16'hFFFF, 32'h0000_0000, 16'h0000);
    send_tuple(32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 16'h0000);
    send_tuple(32'h0000_0000, 16'h0000, 32'h0000_0000, 16'hFFFF);
    send_tuple(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080);
    send_tuple(32'h7F7F_7F7F, 16'h7F7F, 32'h7F7F_7F7F, 16'h7F7F);
  endtask

  // Walk a negative byte through each address byte position to catch byte-order and
  // sign-extension slips; then a few mixed patterns.
  task automatic test_sign_bytes();
    for (int k = 0; k < 4; k++) begin
      send_tuple(32'h80 << (8 * k), 16'h0000, 32'h0000_0000, 16'h0000);
      send_tuple(32'h0000_0000, 16'h0000, 32'h80 << (8 * k), 16'h0000);
    end
    send_tuple(32'h0000_0000, 16'h0080, 32'h0000_0000, 16'h8000);
    send_tuple(32'h0000_0000, 16'h8000, 32'h0000_0000, 16'h0080);
    send_tuple(32'hAA55_AA55, 16'h55AA, 32'h55AA_55AA, 16'hAA55);
    send_tuple(32'h0102_0304, 16'h0506, 32'h0708_090A, 16'h0B0C);
    send_tuple(32'h7F80_FF00, 16'h80FF, 32'h00FF_807F, 16'hFF7F);
  endtask

  // Random tuples: half fully random, half built from boundary-heavy bytes.
  task automatic test_random_tuples(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_tuple($urandom, 16'($urandom), $urandom, 16'($urandom));
      else
        send_tuple(pick_word(), {pick_octet(), pick_octet()},
                   pick_word(), {pick_octet(), pick_octet()});
    end
  endtask

  // Receiver: the stall pattern steps in turn through always ready, a random
  // 3-in-4 ready and a rotating 16-bit mask.
  logic [15:0] ready_mask = 16'hFFFF;
  always @(posedge clk) begin
    case ((cycle_count / 256) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ready_mask[cycle_count % 16];
    endcase
    if (cycle_count % 256 == 0) ready_mask <= 16'($urandom);
  end

  // Compare every accepted word against the oldest expected hash.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected flow_hash %08h", out_tdata));
      end else begin
        if (out_tdata !== pending_hashes[0])
          report_mismatch($sformatf("flow_hash %08h, want %08h",
                                    out_tdata, pending_hashes[0]));
        void'(pending_hashes.pop_front());
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[rs_flow_tuple_hash] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_sign_bytes();
    test_random_tuples(RandomTuples);
    in_tvalid <= 1'b0;

    // Drain, then hold a little longer so stray words still get caught.
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[rs_flow_tuple_hash] OK");
    end else begin
      $display("[rs_flow_tuple_hash] ERROR");
    end
    $finish;
  end

endmodule
